FILE: rtl/drpm_pkg.sv
// drpm_pkg: shared types, register codes and reset values for the dual rc pulse
// measure and regen block; no dependencies
`default_nettype none

package drpm_pkg;

    localparam int CntW = 8;
    localparam int LedW = 16;
    localparam int CfgW = 16;

    localparam logic [CntW-1:0] RstPulseMin  = 8'd100;
    localparam logic [CntW-1:0] RstPulseMax  = 8'd200;
    localparam logic [CntW-1:0] RstNeutral   = 8'd150;
    localparam logic [LedW-1:0] RstLedPeriod = 16'd50000;

    typedef enum logic [1:0] {
        CFG_PULSE_MIN     = 2'd0,
        CFG_PULSE_MAX     = 2'd1,
        CFG_NEUTRAL_WIDTH = 2'd2,
        CFG_LED_PERIOD    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CntW-1:0] pulse_min;
        logic [CntW-1:0] pulse_max;
        logic [CntW-1:0] neutral_width;
        logic [LedW-1:0] led_period;
    } t_cfg;

    typedef struct packed {
        logic in_level_a;
        logic in_level_b;
    } t_in_item;

    typedef struct packed {
        logic            out_level_a;
        logic            out_level_b;
        logic            led_level;
        logic [CntW-1:0] width_a;
        logic [CntW-1:0] width_b;
        logic            new_width_a;
        logic            new_width_b;
    } t_out_item;

    typedef struct packed {
        logic            drive;
        logic [CntW-1:0] width;
        logic            latched;
    } t_chan_res;

endpackage

`default_nettype wire

FILE: rtl/drpm_in_if.sv
// drpm_in_if: valid/ready channel carrying one tick of input levels
// depends on drpm_pkg
`default_nettype none

interface drpm_in_if;
    logic                valid;
    logic                ready;
    drpm_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/drpm_out_if.sv
// drpm_out_if: valid/ready channel carrying one result per tick
// depends on drpm_pkg
`default_nettype none

interface drpm_out_if;
    logic                 valid;
    logic                 ready;
    drpm_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/drpm_chan.sv
// drpm_chan: one channel's idle/active machine, width capture and output timer
// depends on drpm_pkg
`default_nettype none

module drpm_chan (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire logic                 i_level,
    input  wire drpm_pkg::t_cfg       i_cfg,
    output drpm_pkg::t_chan_res       o_res
);

    logic                      r_active, n_active;
    logic                      r_drive, n_drive;
    logic [drpm_pkg::CntW-1:0] r_count, n_count;
    logic [drpm_pkg::CntW-1:0] r_last, n_last;
    logic [drpm_pkg::CntW-1:0] r_timer, n_timer;
    logic [drpm_pkg::CntW-1:0] w_timer;
    logic                      n_latched;

    always_comb begin
        n_active  = r_active;
        n_drive   = r_drive;
        n_count   = r_count;
        n_last    = r_last;
        n_latched = 1'b0;
        w_timer   = r_timer;
        if (!r_active) begin
            if (i_level) begin
                n_active = 1'b1;
                n_count  = '0;
                w_timer  = i_cfg.neutral_width;
                n_drive  = 1'b1;
            end
        end else if (i_level) begin
            if (r_count <= i_cfg.pulse_max) begin
                n_count = drpm_pkg::CntW'(r_count + 1'b1);
            end
        end else begin
            if (r_count <= i_cfg.pulse_max && r_count >= i_cfg.pulse_min) begin
                n_last    = r_count;
                n_latched = 1'b1;
            end
            n_active = 1'b0;
        end
        // output timer runs after the state update
        if (w_timer != '0) begin
            n_timer = drpm_pkg::CntW'(w_timer - 1'b1);
        end else begin
            n_timer = w_timer;
            n_drive = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_drive  <= 1'b0;
            r_count  <= drpm_pkg::RstNeutral;
            r_last   <= drpm_pkg::RstNeutral;
            r_timer  <= drpm_pkg::RstNeutral;
        end else if (i_adv) begin
            r_active <= n_active;
            r_drive  <= n_drive;
            r_count  <= n_count;
            r_last   <= n_last;
            r_timer  <= n_timer;
        end
    end

    assign o_res.drive   = n_drive;
    assign o_res.width   = n_last;
    assign o_res.latched = n_latched;

endmodule

`default_nettype wire

FILE: rtl/drpm_led.sv
// drpm_led: free-running tick counter that toggles the status led each period
// depends on drpm_pkg
`default_nettype none

module drpm_led (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic [drpm_pkg::LedW-1:0] i_period,
    output logic                           o_led
);

    logic [drpm_pkg::LedW-1:0] r_count, n_count;
    logic                      r_led, n_led;
    logic [drpm_pkg::LedW-1:0] w_inc;

    always_comb begin
        w_inc = drpm_pkg::LedW'(r_count + 1'b1);
        if (w_inc == i_period) begin
            n_count = '0;
            n_led   = ~r_led;
        end else begin
            n_count = w_inc;
            n_led   = r_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_led   <= 1'b0;
        end else if (i_adv) begin
            r_count <= n_count;
            r_led   <= n_led;
        end
    end

    assign o_led = n_led;

endmodule

`default_nettype wire

FILE: rtl/dual_rc_pulse_measure_regen_core.sv
// dual_rc_pulse_measure_regen_core: top level with input and result registers,
// config registers, two channels and the led counter
// depends on drpm_pkg, drpm_in_if, drpm_out_if, drpm_chan, drpm_led
//
// usage:
//   i_in carries one 10 us tick per transfer with the levels of inputs a and b.
//   o_out returns exactly one result per tick: regenerated output levels, led
//   level, last valid widths of both channels and their new-width flags.
//   the config port writes pulse_min, pulse_max, neutral_width and led_period
//   by index; the user must make writes only while no tick is in flight, as
//   the block itself does not enforce it. a tick accepted into the input
//   register has its result computed and loaded into the result register when
//   it advances, and the result is then offered on o_out.
//   throughput: one tick per cycle while results are taken, set by the single
//   pass through the channel compare and counter logic between the two registers.
//   a stalled receiver holds the result register; an empty input register still
//   takes one more tick, then i_in.ready stays low until the result is taken.
//   reset (synchronous, active low) restores the register defaults, puts both
//   channels idle with counters at the neutral width and clears the led.
`default_nettype none

module dual_rc_pulse_measure_regen_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    drpm_in_if.sink                        i_in,
    drpm_out_if.source                     o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [drpm_pkg::CfgW-1:0] i_cfg_data
);

    drpm_pkg::t_cfg       r_cfg;
    drpm_pkg::t_in_item   r_in_data;
    logic                 r_in_valid;
    drpm_pkg::t_out_item  r_out_data, n_out_data;
    logic                 r_out_valid;
    logic                 w_adv;
    drpm_pkg::t_chan_res  w_res_a, w_res_b;
    logic                 w_led;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_min     <= drpm_pkg::RstPulseMin;
            r_cfg.pulse_max     <= drpm_pkg::RstPulseMax;
            r_cfg.neutral_width <= drpm_pkg::RstNeutral;
            r_cfg.led_period    <= drpm_pkg::RstLedPeriod;
        end else if (i_cfg_we) begin
            case (drpm_pkg::t_cfg_idx'(i_cfg_idx))
                drpm_pkg::CFG_PULSE_MIN: begin
                    r_cfg.pulse_min <= i_cfg_data[drpm_pkg::CntW-1:0];
                end
                drpm_pkg::CFG_PULSE_MAX: begin
                    r_cfg.pulse_max <= i_cfg_data[drpm_pkg::CntW-1:0];
                end
                drpm_pkg::CFG_NEUTRAL_WIDTH: begin
                    r_cfg.neutral_width <= i_cfg_data[drpm_pkg::CntW-1:0];
                end
                drpm_pkg::CFG_LED_PERIOD: begin
                    r_cfg.led_period <= i_cfg_data[drpm_pkg::LedW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_data <= i_in.data;
        end
    end

    drpm_chan u_chan_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_level (r_in_data.in_level_a),
        .i_cfg   (r_cfg),
        .o_res   (w_res_a)
    );

    drpm_chan u_chan_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_level (r_in_data.in_level_b),
        .i_cfg   (r_cfg),
        .o_res   (w_res_b)
    );

    drpm_led u_led (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_period (r_cfg.led_period),
        .o_led    (w_led)
    );

    always_comb begin
        n_out_data.out_level_a = w_res_a.drive;
        n_out_data.out_level_b = w_res_b.drive;
        n_out_data.led_level   = w_led;
        n_out_data.width_a     = w_res_a.width;
        n_out_data.width_b     = w_res_b.width;
        n_out_data.new_width_a = w_res_a.latched;
        n_out_data.new_width_b = w_res_b.latched;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    a_adv_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out.valid)
        else $error("result register not loaded after advance");

    a_in_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_data))
        else $error("input register lost a tick while stalled");

    a_width_a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.new_width_a |->
            o_out.data.width_a >= r_cfg.pulse_min && o_out.data.width_a <= r_cfg.pulse_max)
        else $error("channel a latched a width outside the valid range");

    a_width_b_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.new_width_b |->
            o_out.data.width_b >= r_cfg.pulse_min && o_out.data.width_b <= r_cfg.pulse_max)
        else $error("channel b latched a width outside the valid range");

endmodule

`default_nettype wire
